// File: hw/rtl/srtp_pkg.sv
// shared types, constants and helper functions for the srt timestamp pair parser
// no dependencies; used by srtp_ms_conv and srt_timestamp_pair_parser_core
package srtp_pkg;

    // window and result widths
    localparam int WIN_LEN    = 12;
    localparam int NUM_DIGITS = 9;
    localparam int TIME_W     = 29;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 2;
    localparam int CSM_W      = 4;

    // stream packing widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // fixed characters of the pattern dd:dd:dd,ddd
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // window slots of the separators
    localparam int POS_COLON_A = 2;
    localparam int POS_COLON_B = 5;
    localparam int POS_COMMA   = 8;

    // window slots of the digits, hours tens first
    localparam int DIGIT_POS [NUM_DIGITS] = '{0, 1, 3, 4, 6, 7, 9, 10, 11};

    // millisecond weight of each digit, same order as DIGIT_POS
    localparam logic [TIME_W-1:0] DIGIT_WEIGHT [NUM_DIGITS] = '{
        29'd36000000, 29'd3600000, 29'd600000, 29'd60000,
        29'd10000,    29'd1000,    29'd100,    29'd10,     29'd1
    };

    // match count values
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    // bytes since last match, saturating at the window length
    localparam logic [CSM_W-1:0] CSM_FULL = 4'(WIN_LEN);

    // one timestamp as nine decimal digits
    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    // finished line waiting for conversion
    typedef struct packed {
        t_bcd first_bcd;
        t_bcd second_bcd;
        logic start_found;
        logic pair_found;
    } t_pend;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // weighted sum of the nine digits
    function automatic logic [TIME_W-1:0] bcd_to_ms(input t_bcd b);
        logic [TIME_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            acc = acc + (TIME_W'(b[i]) * DIGIT_WEIGHT[i]);
        end
        return acc;
    endfunction

endpackage

// File: hw/rtl/srt_timestamp_pair_parser_core.sv
// An accepted tlast beat fills the line register, which then loads the output register.
// Throughput: one character beat per cycle unless stalled; the window shift and the twelve-slot
// compare run in the accept cycle, the millisecond conversion in the output stage.
// Input stalls only while both the line register and the output register are full.
// Reset (synchronous, active low) clears the window, match state and both valid flags.
// Depends on srtp_pkg and srtp_ms_conv.
module srt_timestamp_pair_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [srtp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] char_code
    input  logic                              s_axis_tlast,  // line_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [srtp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [28:0] start_ms, [57:29] end_ms
    output logic [srtp_pkg::OUT_USER_W-1:0]   m_axis_tuser   // [0] start_found, [1] pair_found
);

    logic [srtp_pkg::CHAR_W-1:0] r_win [srtp_pkg::WIN_LEN];
    logic [srtp_pkg::CHAR_W-1:0] n_win [srtp_pkg::WIN_LEN];
    logic [srtp_pkg::CNT_W-1:0]  r_cnt;
    logic [srtp_pkg::CNT_W-1:0]  n_cnt;
    logic [srtp_pkg::CSM_W-1:0]  r_csm;
    logic [srtp_pkg::CSM_W-1:0]  n_csm;
    srtp_pkg::t_bcd              r_first_bcd;
    srtp_pkg::t_bcd              n_first_bcd;
    srtp_pkg::t_bcd              r_second_bcd;
    srtp_pkg::t_bcd              n_second_bcd;
    srtp_pkg::t_bcd              win_bcd;
    srtp_pkg::t_pend             r_pend;
    srtp_pkg::t_pend             n_pend;
    logic                        r_pend_valid;
    logic                        win_match;
    logic                        take;
    logic                        accept;
    logic                        conv_ready;
    logic [srtp_pkg::TIME_W-1:0] start_ms;
    logic [srtp_pkg::TIME_W-1:0] end_ms;
    logic                        start_found;
    logic                        pair_found;

    assign s_axis_tready = !r_pend_valid || conv_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // window after shifting in the new character
    always_comb begin
        for (int i = 0; i < srtp_pkg::WIN_LEN - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[srtp_pkg::WIN_LEN - 1] = s_axis_tdata;
    end

    // pattern compare and digit extraction on the shifted window
    always_comb begin
        win_match = (n_win[srtp_pkg::POS_COLON_A] == srtp_pkg::CHAR_COLON)
                 && (n_win[srtp_pkg::POS_COLON_B] == srtp_pkg::CHAR_COLON)
                 && (n_win[srtp_pkg::POS_COMMA] == srtp_pkg::CHAR_COMMA);
        for (int i = 0; i < srtp_pkg::NUM_DIGITS; i++) begin
            win_match  = win_match && srtp_pkg::is_digit(n_win[srtp_pkg::DIGIT_POS[i]]);
            win_bcd[i] = n_win[srtp_pkg::DIGIT_POS[i]][3:0];
        end
    end

    // match bookkeeping: at most two non-overlapping matches per line
    always_comb begin
        n_csm        = (r_csm < srtp_pkg::CSM_FULL) ? r_csm + 4'd1 : r_csm;
        n_cnt        = r_cnt;
        n_first_bcd  = r_first_bcd;
        n_second_bcd = r_second_bcd;
        take         = (r_cnt < srtp_pkg::CNT_TWO) && (n_csm >= srtp_pkg::CSM_FULL)
                    && win_match;
        if (take) begin
            n_csm = '0;
            n_cnt = r_cnt + 2'd1;
            if (r_cnt == srtp_pkg::CNT_NONE) begin
                n_first_bcd = win_bcd;
            end else begin
                n_second_bcd = win_bcd;
            end
        end
        n_pend.first_bcd   = n_first_bcd;
        n_pend.second_bcd  = n_second_bcd;
        n_pend.start_found = (n_cnt >= srtp_pkg::CNT_ONE);
        n_pend.pair_found  = (n_cnt >= srtp_pkg::CNT_TWO);
    end

    // line state: window, counters and captured digits, cleared at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < srtp_pkg::WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_cnt        <= srtp_pkg::CNT_NONE;
            r_csm        <= srtp_pkg::CSM_FULL;
            r_first_bcd  <= '0;
            r_second_bcd <= '0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                for (int i = 0; i < srtp_pkg::WIN_LEN; i++) begin
                    r_win[i] <= '0;
                end
                r_cnt        <= srtp_pkg::CNT_NONE;
                r_csm        <= srtp_pkg::CSM_FULL;
                r_first_bcd  <= '0;
                r_second_bcd <= '0;
            end else begin
                r_win        <= n_win;
                r_cnt        <= n_cnt;
                r_csm        <= n_csm;
                r_first_bcd  <= n_first_bcd;
                r_second_bcd <= n_second_bcd;
            end
        end
    end

    // finished-line register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (accept && s_axis_tlast) begin
            r_pend_valid <= 1'b1;
        end else if (conv_ready) begin
            r_pend_valid <= 1'b0;
        end
    end

    // finished-line payload
    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_pend <= n_pend;
        end
    end

    srtp_ms_conv u_ms_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_pend_valid),
        .o_ready       (conv_ready),
        .i_pend        (r_pend),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_start_ms    (start_ms),
        .o_end_ms      (end_ms),
        .o_start_found (start_found),
        .o_pair_found  (pair_found)
    );

    // output beat packing
    assign m_axis_tdata = {6'd0, end_ms, start_ms};
    assign m_axis_tuser = {pair_found, start_found};

endmodule

// File: hw/rtl/srtp_ms_conv.sv
// output stage: converts the captured digits of a finished line to milliseconds
// and holds the result beat; depends on srtp_pkg
module srtp_ms_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  srtp_pkg::t_pend             i_pend,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [srtp_pkg::TIME_W-1:0] o_start_ms,
    output logic [srtp_pkg::TIME_W-1:0] o_end_ms,
    output logic                        o_start_found,
    output logic                        o_pair_found
);

    logic                        r_valid;
    logic [srtp_pkg::TIME_W-1:0] r_start_ms;
    logic [srtp_pkg::TIME_W-1:0] r_end_ms;
    logic                        r_start_found;
    logic                        r_pair_found;
    logic [srtp_pkg::TIME_W-1:0] n_start_ms;
    logic [srtp_pkg::TIME_W-1:0] n_end_ms;

    // stage can load when empty or when its beat leaves
    assign o_ready = !r_valid || i_ready;

    // digit to millisecond conversion, zero when not found
    always_comb begin
        n_start_ms = i_pend.start_found ? srtp_pkg::bcd_to_ms(i_pend.first_bcd) : '0;
        n_end_ms   = i_pend.pair_found ? srtp_pkg::bcd_to_ms(i_pend.second_bcd) : '0;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_start_ms    <= n_start_ms;
            r_end_ms      <= n_end_ms;
            r_start_found <= i_pend.start_found;
            r_pair_found  <= i_pend.pair_found;
        end
    end

    assign o_valid       = r_valid;
    assign o_start_ms    = r_start_ms;
    assign o_end_ms      = r_end_ms;
    assign o_start_found = r_start_found;
    assign o_pair_found  = r_pair_found;

endmodule
